// File: src/ast_pkg.sv
package ast_pkg;

	// Parse modes of the front-end state machine
	localparam logic [2:0] MODE_BETWEEN = 3'd0;
	localparam logic [2:0] MODE_ARG     = 3'd1;
	localparam logic [2:0] MODE_ESC     = 3'd2;
	localparam logic [2:0] MODE_QUOTE   = 3'd3;
	localparam logic [2:0] MODE_QESC    = 3'd4;
	localparam logic [2:0] MODE_COMMENT = 3'd5;

	// Result kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Characters of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// One queue entry: the results caused by one text byte (one or two)
	typedef struct packed {
		logic       two;
		logic       kind0;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} ast_entry_t;

	// Handshake between two stages
	typedef struct packed {
		logic valid;
		logic ready;
	} ast_hs_t;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

// File: src/ast_front.sv
module ast_front
	import ast_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output ast_hs_t    push_hs_out,
	input  logic       push_ready,
	output ast_entry_t push_entry
);

	logic [2:0] mode_q;
	logic       open_q;
	logic [2:0] mode_d;
	logic       open_d;
	logic       has_res;
	logic       accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	// Classify the byte and work out the results it causes
	always_comb begin
		mode_d           = mode_q;
		open_d           = open_q;
		has_res          = 1'b0;
		push_entry.two   = 1'b0;
		push_entry.kind0 = KIND_BYTE;
		push_entry.byte0 = text_byte;
		push_entry.byte1 = text_byte;
		unique case (mode_q)
			MODE_ARG: begin
				priority if (text_byte == CH_NUL || is_space(text_byte)) begin
					has_res          = 1'b1;
					push_entry.kind0 = KIND_END;
					push_entry.byte0 = CH_NUL;
					open_d           = 1'b0;
					mode_d           = MODE_BETWEEN;
				end else if (text_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else if (text_byte == CH_QUOTE) begin
					mode_d = MODE_QUOTE;
				end else if (text_byte == CH_HASH) begin
					has_res          = 1'b1;
					push_entry.kind0 = KIND_END;
					push_entry.byte0 = CH_NUL;
					open_d           = 1'b0;
					mode_d           = MODE_COMMENT;
				end else begin
					has_res = 1'b1;
				end
			end
			MODE_ESC: begin
				priority if (text_byte == CH_NUL) begin
					has_res          = 1'b1;
					push_entry.kind0 = KIND_END;
					open_d           = 1'b0;
					mode_d           = MODE_BETWEEN;
				end else if (text_byte == CH_LF || text_byte == CH_CR) begin
					mode_d = open_q ? MODE_ARG : MODE_BETWEEN;
				end else begin
					has_res = 1'b1;
					open_d  = 1'b1;
					mode_d  = MODE_ARG;
				end
			end
			MODE_QUOTE: begin
				priority if (text_byte == CH_NUL) begin
					has_res          = 1'b1;
					push_entry.kind0 = KIND_END;
					open_d           = 1'b0;
					mode_d           = MODE_BETWEEN;
				end else if (text_byte == CH_QUOTE) begin
					mode_d = MODE_ARG;
				end else if (text_byte == CH_BSLASH) begin
					mode_d = MODE_QESC;
				end else begin
					has_res = 1'b1;
				end
			end
			MODE_QESC: begin
				priority if (text_byte == CH_NUL) begin
					has_res          = 1'b1;
					push_entry.kind0 = KIND_END;
					open_d           = 1'b0;
					mode_d           = MODE_BETWEEN;
				end else if (text_byte == CH_BSLASH || text_byte == CH_QUOTE) begin
					has_res = 1'b1;
					mode_d  = MODE_QUOTE;
				end else if (text_byte == CH_LF || text_byte == CH_CR) begin
					mode_d = MODE_QUOTE;
				end else begin
					// keep the backslash, then the byte
					has_res          = 1'b1;
					push_entry.two   = 1'b1;
					push_entry.byte0 = CH_BSLASH;
					mode_d           = MODE_QUOTE;
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_NUL || text_byte == CH_LF) begin
					mode_d = MODE_BETWEEN;
				end
			end
			default: begin
				mode_d = MODE_BETWEEN;
				priority if (text_byte == CH_NUL || is_space(text_byte)) begin
					open_d = 1'b0;
				end else if (text_byte == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (text_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else if (text_byte == CH_QUOTE) begin
					open_d = 1'b1;
					mode_d = MODE_QUOTE;
				end else begin
					has_res = 1'b1;
					open_d  = 1'b1;
					mode_d  = MODE_ARG;
				end
			end
		endcase
	end

	assign push_hs_out.valid = accept && has_res;
	assign push_hs_out.ready = push_ready;

	// Advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			open_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			open_q <= open_d;
		end
	end

`ifndef SYNTHESIS
	// Inside an argument or quotes an end mark is always owed
	a_open_in_arg: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_ARG || mode_q == MODE_QUOTE || mode_q == MODE_QESC) |-> open_q)
		else $error("argument mode without open argument");
	// A byte that pushes results is accepted only when the queue has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_hs_out.valid |-> push_ready)
		else $error("push without queue room");
`endif

endmodule

// File: src/ast_queue.sv
module ast_queue
	import ast_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       push_ready,
	input  ast_entry_t push_entry,
	output ast_hs_t    pop_hs,
	input  logic       pop,
	output ast_entry_t pop_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ast_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready   = (count_q != CW'(DEPTH));
	assign pop_hs.valid = (count_q != '0);
	assign pop_hs.ready = pop;
	assign pop_entry    = mem_q[rd_ptr_q];
	assign do_push      = push && push_ready;
	assign do_pop       = pop && pop_hs.valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy out of range");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");
`endif

endmodule

// File: src/ast_back.sv
module ast_back
	import ast_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ast_hs_t    pop_hs,
	output logic       pop,
	input  ast_entry_t pop_entry,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       load;

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !pend_q && pop_hs.valid;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Hold the output transaction; feed the second result before the next entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= pop_hs.valid;
				pend_q      <= pop_hs.valid && pop_entry.two;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_kind_q <= KIND_BYTE;
				out_byte_q <= pend_byte_q;
				out_last_q <= 1'b1;
			end else if (pop_hs.valid) begin
				out_kind_q  <= pop_entry.kind0;
				out_byte_q  <= pop_entry.byte0;
				out_last_q  <= !pop_entry.two;
				pend_byte_q <= pop_entry.byte1;
			end
		end
	end

`ifndef SYNTHESIS
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && !out_last_q))
		else $error("second result pending without first on output");
	a_no_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !pop)
		else $error("entry taken while second result pending");
`endif

endmodule

// File: src/argument_string_tokenizer.sv
// Channel   Dir  Bits of tdata / tuser / tlast
// s_axis    in   tdata[7:0] text_byte
// m_axis    out  tdata[7:0] arg_byte, tuser kind, tlast last_of_run
//
// One text byte is taken per cycle while the queue has room. A byte that yields one result
// gives one output transaction; a byte inside quotes that keeps its backslash yields two.
// A result passes through the queue write and then the output register before it appears.
// The queue of QUEUE_DEPTH entries lets input continue while the output is stalled;
// s_axis_tready falls only when the queue is full.
// Reset clears parse state, queue occupancy and the output valid and pending flags.
module argument_string_tokenizer
	import ast_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] arg_byte
	output logic       m_axis_tuser,  // [0] kind
	output logic       m_axis_tlast
);

	ast_hs_t    push_hs;
	ast_hs_t    pop_hs;
	ast_entry_t push_entry;
	ast_entry_t pop_entry;
	logic       push_ready;
	logic       pop;

	// Classify bytes and run the parse state
	ast_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.text_byte   (s_axis_tdata),
		.push_hs_out (push_hs),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	// Decouple front from back
	ast_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_hs.valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_hs     (pop_hs),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	// Emit results one transaction at a time
	ast_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_hs    (pop_hs),
		.pop       (pop),
		.pop_entry (pop_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
